@@ rtl/lfubc_pkg.sv @@
package lfubc_pkg;

   localparam int unsigned DEFAULT_ENTRIES  = 256;
   localparam int unsigned MAX_INSERT_DISK  = 16;
   localparam int unsigned MAX_INSERT_BLOCK = 256;

   localparam int unsigned OP_W        = 2;
   localparam int unsigned DISK_W      = 5;
   localparam int unsigned BLOCK_W     = 9;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned SLOT_W      = 8;
   localparam int unsigned TOTAL_W     = 32;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 9;

   localparam logic [CSR_DATA_W-1:0] ENTRIES_RESET = 9'd256;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_UPDATE = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE  = 1'b0,
      CSR_ENTRIES = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [DISK_W-1:0]  disk_id;
      logic [BLOCK_W-1:0] block_id;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [SLOT_W-1:0]  slot;
      logic [TOTAL_W-1:0] hit_total;
      logic [TOTAL_W-1:0] query_total;
   } rsp_type;

   typedef struct packed {
      logic [DISK_W-1:0]  disk;
      logic [BLOCK_W-1:0] block;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic set_valid;
      logic clear_all;
   } store_ctrl_type;

endpackage

@@ rtl/lfubc_store.sv @@
module lfubc_store import lfubc_pkg::*; #(
   parameter int unsigned ENTRIES = DEFAULT_ENTRIES,
   localparam int unsigned IDX_W = $clog2(ENTRIES)
) (
   input  logic           clock,
   input  logic           reset,
   input  store_ctrl_type ctrl,
   input  logic [IDX_W-1:0] rd_idx,
   input  logic [IDX_W-1:0] wr_idx,
   input  entry_type      wr_entry,
   output entry_type      rd_entry,
   output logic           rd_valid
);

   entry_type        mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   entry_type        rd_entry_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_idx];
      rd_valid_ff <= valid_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.clear_all) begin
         valid_ff <= '0;
      end else if (ctrl.set_valid) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

@@ rtl/lfu_block_cache_tags_unit.sv @@
// Sequence: a disabled, rejected or early-failing item goes straight to the result state;
//   otherwise the scan visits n active slots (n = entries_in_use clamped to 2..ENTRIES),
//   inserts then take a fill step, and the result state follows (lookup hits stop early).
// Items: one at a time, accepted only while idle; the scan uses the single read port
//   of the tag store, which is visited once per slot.
//   The receiver cannot stall the result.
// Reset: synchronous; clears all valid bits, statistics and enable (entries_in_use 256).
module lfu_block_cache_tags_unit import lfubc_pkg::*; #(
   parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam int unsigned LIM_W = (CNT_W > CSR_DATA_W) ? CNT_W : CSR_DATA_W;

   state_type             state_ff, state_in;
   logic                  enable_ff, enable_in;
   logic [CSR_DATA_W-1:0] entries_ff, entries_in;
   logic                  any_ins_ff, any_ins_in;
   logic [TOTAL_W-1:0]    hits_ff, hits_in;
   logic [TOTAL_W-1:0]    queries_ff, queries_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  cmp_vld_ff, cmp_vld_in;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [DISK_W-1:0]     disk_ff, disk_in;
   logic [BLOCK_W-1:0]    block_ff, block_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                  dup_ff, dup_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0]    best_ff, best_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic                  status_ff, status_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;

   logic [LIM_W-1:0]      lim_ext;
   logic [LIM_W-1:0]      active_n;
   logic [IDX_W-1:0]      last_idx;
   logic                  accept;
   logic                  early_fail;
   logic                  in_range;
   logic                  key_match;
   logic                  cmp_last;
   logic [COUNT_W-1:0]    count_inc;
   logic [IDX_W-1:0]      fill_idx;

   store_ctrl_type        st_ctrl;
   logic [IDX_W-1:0]      st_wr_idx;
   entry_type             st_wr_entry;
   entry_type             st_rd_entry;
   logic                  st_rd_valid;

   lfubc_store #(
      .ENTRIES(ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (st_ctrl),
      .rd_idx   (rd_idx_ff),
      .wr_idx   (st_wr_idx),
      .wr_entry (st_wr_entry),
      .rd_entry (st_rd_entry),
      .rd_valid (st_rd_valid)
   );

   // Clamp the slot count to 2..ENTRIES
   always_comb begin
      lim_ext = LIM_W'(entries_ff);
      if (lim_ext < LIM_W'(2)) begin
         active_n = LIM_W'(2);
      end else if (lim_ext > LIM_W'(ENTRIES)) begin
         active_n = LIM_W'(ENTRIES);
      end else begin
         active_n = lim_ext;
      end
      last_idx = IDX_W'(active_n - LIM_W'(1));
   end

   assign accept    = start && (state_ff == ST_IDLE);
   assign in_range  = (req_data.disk_id <= DISK_W'(MAX_INSERT_DISK))
                   && (req_data.block_id <= BLOCK_W'(MAX_INSERT_BLOCK));
   assign key_match = cmp_vld_ff && st_rd_valid
                   && (st_rd_entry.disk == disk_ff) && (st_rd_entry.block == block_ff);
   assign cmp_last  = cmp_vld_ff && (cmp_idx_ff == last_idx);
   assign count_inc = (st_rd_entry.count == '1) ? st_rd_entry.count
                                               : st_rd_entry.count + COUNT_W'(1);
   assign fill_idx  = free_found_ff ? free_idx_ff : best_idx_ff;

   always_comb begin
      case (req_data.opcode)
         OP_LOOKUP: early_fail = !enable_ff || !any_ins_ff;
         OP_INSERT: early_fail = !enable_ff || !in_range;
         OP_UPDATE: early_fail = !enable_ff;
         default:   early_fail = 1'b1;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = early_fail ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((op_ff == OP_LOOKUP) && key_match) begin
               state_in = ST_RESP;
            end else if (cmp_last) begin
               state_in = (op_ff == OP_INSERT) ? ST_FILL : ST_RESP;
            end
         end
         ST_FILL: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and store control
   always_comb begin
      enable_in     = enable_ff;
      entries_in    = entries_ff;
      any_ins_in    = any_ins_ff;
      hits_in       = hits_ff;
      queries_in    = queries_ff;
      rd_idx_in     = rd_idx_ff;
      issue_done_in = issue_done_ff;
      cmp_vld_in    = 1'b0;
      op_in         = op_ff;
      disk_in       = disk_ff;
      block_in      = block_ff;
      cmp_idx_in    = cmp_idx_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      st_ctrl       = '0;
      st_wr_idx     = cmp_idx_ff;
      st_wr_entry   = '{disk: disk_ff, block: block_ff, count: count_inc};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in         = req_data.opcode;
               disk_in       = req_data.disk_id;
               block_in      = req_data.block_id;
               rd_idx_in     = '0;
               issue_done_in = 1'b0;
               dup_in        = 1'b0;
               free_found_in = 1'b0;
               status_in     = 1'b1;
               slot_in       = '0;
               if (!early_fail && (req_data.opcode == OP_LOOKUP)) begin
                  queries_in = (queries_ff == '1) ? queries_ff : queries_ff + TOTAL_W'(1);
               end
               // a duplicate still marks the cache as used
               if (!early_fail && (req_data.opcode == OP_INSERT)) begin
                  any_ins_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // advance the read address one slot a cycle
            cmp_vld_in = !issue_done_ff;
            cmp_idx_in = rd_idx_ff;
            if (!issue_done_ff) begin
               if (rd_idx_ff == last_idx) begin
                  issue_done_in = 1'b1;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            if (cmp_vld_ff) begin
               case (op_ff)
                  OP_LOOKUP: begin
                     if (key_match) begin
                        hits_in       = (hits_ff == '1) ? hits_ff : hits_ff + TOTAL_W'(1);
                        st_ctrl.wr_en = 1'b1;
                        status_in     = 1'b0;
                        slot_in       = SLOT_W'(cmp_idx_ff);
                        cmp_vld_in    = 1'b0;
                     end
                  end
                  OP_UPDATE: begin
                     if (key_match) begin
                        st_ctrl.wr_en = 1'b1;
                        if (status_ff) begin
                           status_in = 1'b0;
                           slot_in   = SLOT_W'(cmp_idx_ff);
                        end
                     end
                  end
                  OP_INSERT: begin
                     if (key_match) begin
                        dup_in = 1'b1;
                     end
                     if (!st_rd_valid && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = cmp_idx_ff;
                     end
                     // victim: lowest index with the smallest count
                     if ((cmp_idx_ff == '0) || (st_rd_entry.count < best_ff)) begin
                        best_in     = st_rd_entry.count;
                        best_idx_in = cmp_idx_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            st_wr_idx   = fill_idx;
            st_wr_entry = '{disk: disk_ff, block: block_ff, count: COUNT_W'(1)};
            if (!dup_ff) begin
               st_ctrl.wr_en     = 1'b1;
               st_ctrl.set_valid = 1'b1;
               status_in         = 1'b0;
               slot_in           = SLOT_W'(fill_idx);
            end
         end
         default: ;
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE: begin
               enable_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  any_ins_in        = 1'b0;
                  st_ctrl.clear_all = 1'b1;
               end
            end
            CSR_ENTRIES: entries_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Outputs
   always_comb begin
      busy                 = (state_ff != ST_IDLE);
      rsp_strobe           = (state_ff == ST_RESP);
      rsp_data.status      = status_ff;
      rsp_data.slot        = slot_ff;
      rsp_data.hit_total   = hits_ff;
      rsp_data.query_total = queries_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b0;
         entries_ff    <= ENTRIES_RESET;
         any_ins_ff    <= 1'b0;
         hits_ff       <= '0;
         queries_ff    <= '0;
         rd_idx_ff     <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         entries_ff    <= entries_in;
         any_ins_ff    <= any_ins_in;
         hits_ff       <= hits_in;
         queries_ff    <= queries_in;
         rd_idx_ff     <= rd_idx_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      disk_ff       <= disk_in;
      block_ff      <= block_in;
      cmp_idx_ff    <= cmp_idx_in;
      dup_ff        <= dup_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
   end

endmodule

@@ rtl/lfubc_checker.sv @@
module lfubc_checker import lfubc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // every accepted item holds the block busy until its result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result transfer while not busy");

   // one result per item, then ready again
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe held or block stayed busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.hit_total <= rsp_data.query_total))
      else $error("more hits than queries");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status) |-> (rsp_data.slot == '0))
      else $error("failed result with nonzero slot");

endmodule

bind lfu_block_cache_tags_unit lfubc_checker u_lfubc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
